// ----- sv/rdc_pkg.sv -----
// ----------------------------------------------------------------------------
// rdc_pkg
// Types, constants and helpers shared by the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Bits of the input value that take part in the conversion
  localparam int ValueWidth = 32;
  localparam int CntWidth   = $clog2(ValueWidth);

  localparam int InValueWidth = 32;
  localparam int RadixWidth   = 6;
  localparam int CharWidth    = 7;

  localparam logic [RadixWidth-1:0] MinRadix = RadixWidth'(2);
  localparam logic [RadixWidth-1:0] MaxRadix = RadixWidth'(36);

  localparam logic [CharWidth-1:0] CharZero = CharWidth'(48);  // '0'
  localparam logic [CharWidth-1:0] CharA    = CharWidth'(65);  // 'A'

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } rdc_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;     // take a new item
    logic step;     // one restoring division step
    logic restart;  // divide the quotient again for the next digit
    logic emit;     // load the output register with the remainder
  } rdc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_last;  // current step is the final one of this division
    logic quot_zero;  // quotient is zero: this digit ends the run
    logic out_free;   // output register can take a digit this cycle
  } rdc_status_t;

  function automatic logic [RadixWidth-1:0] sat_radix(input logic [RadixWidth-1:0] r);
    logic [RadixWidth-1:0] res;
    res = r;
    if (r < MinRadix) res = MinRadix;
    if (r > MaxRadix) res = MaxRadix;
    return res;
  endfunction

  // '0'-'9' then 'A'-'Z'
  function automatic logic [CharWidth-1:0] digit_to_char(input logic [RadixWidth-1:0] d);
    logic [CharWidth-1:0] res;
    if (d < RadixWidth'(10)) begin
      res = CharZero + CharWidth'(d);
    end else begin
      res = CharA + CharWidth'(d) - CharWidth'(10);
    end
    return res;
  endfunction

endpackage

// ----- sv/rdc_if.sv -----
// ----------------------------------------------------------------------------
// rdc_if
// Valid/ready channels of the radix digit converter: input item and digit.
// ----------------------------------------------------------------------------
interface rdc_in_if
  import rdc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [InValueWidth-1:0] value;
  logic [RadixWidth-1:0]   radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rdc_out_if
  import rdc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CharWidth-1:0]  digit_char;
  logic [RadixWidth-1:0] digit_value;
  logic                  last_digit;

  modport source (output valid, output digit_char, output digit_value, output last_digit,
                  input ready);
  modport sink   (input valid, input digit_char, input digit_value, input last_digit,
                  output ready);
endinterface

// ----- sv/rdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: accept an item, run one division per digit, hand each digit on.
// ----------------------------------------------------------------------------
module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rdc_status_t status_i,
  output rdc_cmd_t    cmd_o
);

  rdc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.step_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.quot_zero ? ST_IDLE : ST_DIV;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit    = status_i.out_free;
        cmd_o.restart = status_i.out_free && !status_i.quot_zero;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/rdc_dp.sv -----
// ----------------------------------------------------------------------------
// rdc_dp
// Datapath: bit-serial restoring divider by the radix and the digit register.
// ----------------------------------------------------------------------------
module rdc_dp
  import rdc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rdc_cmd_t                cmd_i,
  output rdc_status_t             status_o,
  input  logic [InValueWidth-1:0] value_i,
  input  logic [RadixWidth-1:0]   radix_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CharWidth-1:0]    digit_char_o,
  output logic [RadixWidth-1:0]   digit_value_o,
  output logic                    last_digit_o
);

  logic [ValueWidth-1:0] quot_q, quot_d;
  logic [RadixWidth-1:0] rem_q, rem_d;
  logic [RadixWidth-1:0] radix_q;
  logic [CntWidth-1:0]   cnt_q, cnt_d;

  logic                  out_valid_q, out_valid_d;
  logic [CharWidth-1:0]  char_q;
  logic [RadixWidth-1:0] dval_q;
  logic                  last_q;

  logic [RadixWidth:0]   trial;
  logic [RadixWidth:0]   diff;
  logic                  fits;

  // Shift the next dividend bit into the partial remainder and try the radix
  assign trial = {rem_q, quot_q[ValueWidth-1]};
  assign diff  = trial - {1'b0, radix_q};
  assign fits  = trial >= {1'b0, radix_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (cmd_i.load) begin
      quot_d = ValueWidth'(value_i);
      rem_d  = '0;
      cnt_d  = '0;
    end else if (cmd_i.restart) begin
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.step) begin
      quot_d = {quot_q[ValueWidth-2:0], fits};
      rem_d  = fits ? diff[RadixWidth-1:0] : trial[RadixWidth-1:0];
      cnt_d  = cnt_q + CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    if (cmd_i.load) radix_q <= sat_radix(radix_i);
    if (cmd_i.emit) begin
      char_q <= digit_to_char(rem_q);
      dval_q <= rem_q;
      last_q <= (quot_q == '0);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.step_last = (cnt_q == CntWidth'(ValueWidth - 1));
  assign status_o.quot_zero = (quot_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign digit_char_o  = char_q;
  assign digit_value_o = dval_q;
  assign last_digit_o  = last_q;

endmodule

// ----- sv/radix_digit_converter.sv -----
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts an unsigned value to ASCII digits in a radix of 2 to 36.
// ----------------------------------------------------------------------------
// One input transfer gives one output transfer per digit, least significant
// first, the final one flagged by last_digit; a zero value gives a single '0'.
// A radix below 2 is treated as 2 and one above 36 as 36. Each digit comes
// from a restoring division by the radix that retires one quotient bit per
// cycle, and the remainder then goes into the output register once that is
// free. Items are handled one at a time; the next item is taken as soon as
// its predecessor's last digit sits in the output register.
// ----------------------------------------------------------------------------
module radix_digit_converter
  import rdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  rdc_in_if.sink    in_if,
  rdc_out_if.source out_if
);

  rdc_cmd_t    cmd;
  rdc_status_t status;

  rdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rdc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .value_i       (in_if.value),
    .radix_i       (in_if.radix),
    .out_valid_o   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .digit_char_o  (out_if.digit_char),
    .digit_value_o (out_if.digit_value),
    .last_digit_o  (out_if.last_digit)
  );

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the radix digit converter.
// ----------------------------------------------------------------------------
// A table of corner values is converted first. Random values and radices
// follow, in three phases with different idling on each channel. Every digit
// is checked against a digit list. Where it is obvious, that list is typed into
// the table. Otherwise a behavioural divider works it out.
// ----------------------------------------------------------------------------
module testbench
  import rdc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumProbes    = 23;
  localparam int NumRandom    = 450;
  localparam int LongHoldCyc  = 400;
  localparam int DrainCyc     = 100;
  localparam int MaxReported  = 10;

  typedef struct packed {
    logic [CharWidth-1:0]  char_code;
    logic [RadixWidth-1:0] value;
    logic                  last;
  } digit_t;

  typedef struct {
    logic [InValueWidth-1:0] value;
    logic [RadixWidth-1:0]   radix;
    string                   text;  // expected number, most significant first
  } probe_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rdc_in_if  in_ch ();
  rdc_out_if out_ch ();

  radix_digit_converter DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #5 clk = ~clk;

  digit_t pending_digits[$];
  int     mismatches  = 0;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  logic   long_hold_q = 1'b0;

  probe_t probes [NumProbes] = '{
    '{32'h0000_0000, 6'd10, "0"},
    '{32'h0000_0000, 6'd0,  "0"},
    '{32'h0000_0000, 6'd63, "0"},
    '{32'h0000_0001, 6'd0,  "1"},
    '{32'h0000_0002, 6'd1,  "10"},
    '{32'h0000_0003, 6'd0,  "11"},
    '{32'h0000_0023, 6'd36, "Z"},
    '{32'h0000_0023, 6'd37, "Z"},
    '{32'h0000_0024, 6'd63, "10"},
    '{32'h0000_0009, 6'd10, "9"},
    '{32'h0000_000A, 6'd11, "A"},
    '{32'h0000_000F, 6'd16, "F"},
    '{32'hFFFF_FFFF, 6'd16, "FFFFFFFF"},
    '{32'hFFFF_FFFF, 6'd2,  "11111111111111111111111111111111"},
    '{32'h8000_0000, 6'd2,  "10000000000000000000000000000000"},
    '{32'hFFFF_FFFF, 6'd10, "4294967295"},
    '{32'h0000_0001, 6'd36, "1"},
    '{32'hFFFF_FFFF, 6'd36, ""},
    '{32'hFFFF_FFFF, 6'd1,  ""},
    '{32'hAAAA_AAAA, 6'd7,  ""},
    '{32'h5555_5555, 6'd3,  ""},
    '{32'hDEAD_BEEF, 6'd62, ""},
    '{32'h7FFF_FFFF, 6'd35, ""}
  };

  // Repeated division, least significant digit first
  function automatic void predict_digits(input logic [InValueWidth-1:0] value,
                                         input logic [RadixWidth-1:0]   radix);
    logic [ValueWidth-1:0] quot;
    int unsigned           base;
    int unsigned           rem;
    digit_t                d;
    base = 32'(radix);
    if (base < MinRadix) base = 32'(MinRadix);
    if (base > MaxRadix) base = 32'(MaxRadix);
    quot = value[ValueWidth-1:0];
    if (quot == '0) begin
      pending_digits.push_back('{CharZero, '0, 1'b1});
    end else begin
      while (quot != '0) begin
        rem          = quot % base;
        quot         = quot / base;
        d.value      = RadixWidth'(rem);
        d.char_code  = (rem < 10) ? CharWidth'(48 + rem) : CharWidth'(55 + rem);
        d.last       = (quot == '0);
        pending_digits.push_back(d);
      end
    end
  endfunction

  function automatic void digits_from_text(input string text);
    byte    c;
    digit_t d;
    for (int i = text.len() - 1; i >= 0; i--) begin
      c           = text[i];
      d.char_code = c[CharWidth-1:0];
      d.value     = (c >= "A") ? RadixWidth'(c - 55) : RadixWidth'(c - 48);
      d.last      = (i == 0);
      pending_digits.push_back(d);
    end
  endfunction

  function automatic void note_mismatch(input string what, input digit_t exp_d,
                                        input digit_t got_d);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("%0t: %s: expected char %0d value %0d last %0b, got char %0d value %0d last %0b",
               $realtime, what, exp_d.char_code, exp_d.value, exp_d.last,
               got_d.char_code, got_d.value, got_d.last);
  endfunction

  task automatic send_item(input logic [InValueWidth-1:0] value,
                           input logic [RadixWidth-1:0]   radix,
                           input string                   text);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.radix <= radix;
    do @(posedge clk); while (!in_ch.ready);
    if (text.len() != 0) digits_from_text(text);
    else predict_digits(value, radix);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  task automatic send_random();
    logic [InValueWidth-1:0] value;
    logic [RadixWidth-1:0]   radix;
    case ($urandom_range(0, 3))
      0:       value = $urandom;
      1:       value = $urandom >> $urandom_range(0, 31);
      2:       value = $urandom_range(0, 40);
      default: value = 32'hFFFF_FFFF >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 4) == 0) radix = RadixWidth'($urandom_range(0, 63));
    else radix = RadixWidth'($urandom_range(2, 36));
    send_item(value, radix, "");
  endtask

  // Digit checker
  always @(posedge clk) begin
    digit_t got_d;
    digit_t exp_d;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_d = '{out_ch.digit_char, out_ch.digit_value, out_ch.last_digit};
      if (pending_digits.size() == 0) begin
        note_mismatch("unexpected digit", '0, got_d);
      end else begin
        exp_d = pending_digits.pop_front();
        if (got_d.char_code !== exp_d.char_code || got_d.value !== exp_d.value ||
            got_d.last !== exp_d.last)
          note_mismatch("digit mismatch", exp_d, got_d);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off in the last phase
  initial begin
    int hold_left;
    hold_left = LongHoldCyc;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_q && hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.radix <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 10;
    rx_idle_pct = 46;
    foreach (probes[i]) send_item(probes[i].value, probes[i].radix, probes[i].text);
    wait_drained();

    for (int i = 0; i < NumRandom / 3; i++) send_random();
    wait_drained();

    tx_idle_pct = 46;
    rx_idle_pct = 10;
    for (int i = 0; i < NumRandom / 3; i++) send_random();

    // no idling; the receiver stalls long enough for the input to back up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold_q <= 1'b1;
    for (int i = 0; i < NumRandom / 3; i++) send_random();

    wait_drained();
    repeat (DrainCyc) @(posedge clk);
    if (mismatches == 0 && pending_digits.size() == 0) begin
      $display("** radix_digit_converter: PASSED **");
    end else begin
      $display("** radix_digit_converter: FAILED **");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("** radix_digit_converter: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
sv/rdc_pkg.sv
sv/rdc_if.sv
sv/rdc_ctrl.sv
sv/rdc_dp.sv
sv/radix_digit_converter.sv
sim/testbench.sv
